FILE: sv/itad_pkg.sv
// Shared types, constants and helpers for the integer to ASCII formatter.
// No dependencies; compile first.
package itad_pkg;

	localparam int VALUE_W     = 64;
	localparam int CHAR_W      = 7;
	localparam int BASE_W      = 5;
	localparam int MAX_CHARS   = 20;
	localparam int IDX_W       = $clog2(MAX_CHARS + 1);
	localparam int QUEUE_DEPTH = 2;

	// Long division retires DIV_BITS quotient bits per cycle.
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = VALUE_W / DIV_BITS;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam int NIB_W     = 4;
	localparam int PTR_CHARS = 2 + VALUE_W / NIB_W;

	localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(10);
	localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);

	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;
	localparam logic [CHAR_W-1:0] CH_LA    = 7'h61;

	localparam logic CMD_INT = 1'b0;
	localparam logic CMD_PTR = 1'b1;

	typedef struct packed {
		logic                ptr;
		logic                neg;
		logic [BASE_W-1:0]   base;
		logic [VALUE_W-1:0]  mag;
	} desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = CHAR_W'(d);
		if (d < NIB_W'(10))
			return CH_ZERO + dx;
		return CH_LA + dx - CHAR_W'(10);
	endfunction

endpackage

FILE: sv/itad_if.sv
// Handshake channels of the formatter: number items in, character items out.
// Depends on itad_pkg.
interface itad_num_if;
	logic                         valid;
	logic                         ready;
	logic                         cmd;
	logic [itad_pkg::VALUE_W-1:0] value;
	logic                         signed_mode;
	logic [itad_pkg::BASE_W-1:0]  base;

	modport source(output valid, cmd, value, signed_mode, base, input ready);
	modport sink(input valid, cmd, value, signed_mode, base, output ready);
endinterface

interface itad_text_if;
	logic                        valid;
	logic                        ready;
	logic [itad_pkg::CHAR_W-1:0] character;
	logic                        last;

	modport source(output valid, character, last, input ready);
	modport sink(input valid, character, last, output ready);
endinterface

FILE: sv/itad_front.sv
// Front end: accepts number items, clamps the base, takes the magnitude.
// Depends on itad_pkg and itad_if.
module itad_front (
	itad_num_if.sink          num,
	input  itad_pkg::q_stat_t q_stat,
	output logic              push,
	output itad_pkg::desc_t   push_desc
);
	import itad_pkg::*;

	logic neg;

	assign num.ready = !q_stat.full;
	assign push      = num.valid && !q_stat.full;
	assign neg       = (num.cmd == CMD_INT) && num.signed_mode && num.value[VALUE_W-1];

	always_comb begin
		push_desc.ptr = (num.cmd == CMD_PTR);
		push_desc.neg = neg;
		push_desc.mag = neg ? (~num.value + VALUE_W'(1)) : num.value;
		if (num.base < BASE_MIN)
			push_desc.base = BASE_MIN;
		else if (num.base > BASE_MAX)
			push_desc.base = BASE_MAX;
		else
			push_desc.base = num.base;
	end
endmodule

FILE: sv/itad_queue.sv
// Short descriptor queue between front and back end.
// Depends on itad_pkg.
module itad_queue #(
	parameter int DEPTH = itad_pkg::QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  itad_pkg::desc_t                   push_desc,
	input  logic                              pop,
	output itad_pkg::desc_t                   pop_desc,
	output itad_pkg::q_stat_t                 stat,
	output logic [$clog2(DEPTH+1)-1:0]        level
);
	import itad_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	desc_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [LW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign stat.full  = (cnt_q == LW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign level      = cnt_q;
	assign pop_desc   = mem_q[rd_q];
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (do_pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + LW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - LW'(1);
		end
	end
endmodule

FILE: sv/itad_back.sv
// Back end: digit extraction by long division, digit buffer, output register.
// Depends on itad_pkg and itad_if.
module itad_back (
	input  logic              clk,
	input  logic              arst_n,
	input  itad_pkg::q_stat_t q_stat,
	input  itad_pkg::desc_t   pop_desc,
	output logic              pop,
	itad_text_if.source       text
);
	import itad_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;

	state_t              state_q;
	logic                ptr_q;
	logic                sign_q;
	logic [BASE_W-1:0]   base_q;
	logic [VALUE_W-1:0]  quot_q;
	logic [NIB_W-1:0]    rem_q;
	logic [STEP_W-1:0]   step_q;
	logic [IDX_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    idx_q;
	logic [CHAR_W-1:0]   buf_q [MAX_CHARS];
	logic                ovalid_q;
	logic [CHAR_W-1:0]   ochar_q;
	logic                olast_q;

	logic [NIB_W-1:0]    div_rem;
	logic [NIB_W:0]      div_r5;
	logic [VALUE_W-1:0]  div_quot;
	logic                load;
	logic [IDX_W-1:0]    rd_idx;

	assign text.valid     = ovalid_q;
	assign text.character = ochar_q;
	assign text.last      = olast_q;
	assign load           = !ovalid_q || text.ready;
	assign pop            = (state_q == ST_IDLE) && !q_stat.empty;
	assign rd_idx         = idx_q - IDX_W'(1);

	always_comb begin
		div_rem  = rem_q;
		div_quot = quot_q;
		div_r5   = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			div_r5   = {div_rem, div_quot[VALUE_W-1]};
			div_quot = {div_quot[VALUE_W-2:0], 1'b0};
			if (div_r5 >= base_q) begin
				div_r5      = div_r5 - base_q;
				div_quot[0] = 1'b1;
			end
			div_rem = div_r5[NIB_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && step_q == STEP_W'(DIV_STEPS - 1))
			buf_q[cnt_q[IDX_W-1:0]] <= digit_char(div_rem);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ptr_q    <= 1'b0;
			sign_q   <= 1'b0;
			base_q   <= BASE_MIN;
			quot_q   <= '0;
			rem_q    <= '0;
			step_q   <= '0;
			cnt_q    <= '0;
			idx_q    <= '0;
			ovalid_q <= 1'b0;
			ochar_q  <= '0;
			olast_q  <= 1'b0;
		end else begin
			if (text.ready && !(state_q == ST_EMIT && load))
				ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_stat.empty) begin
						ptr_q  <= pop_desc.ptr;
						sign_q <= pop_desc.neg;
						base_q <= pop_desc.base;
						quot_q <= pop_desc.mag;
						rem_q  <= '0;
						step_q <= '0;
						cnt_q  <= '0;
						idx_q  <= '0;
						state_q <= pop_desc.ptr ? ST_EMIT : ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						cnt_q  <= cnt_q + IDX_W'(1);
						rem_q  <= '0;
						step_q <= '0;
						quot_q <= div_quot;
						if (div_quot == '0) begin
							idx_q   <= cnt_q + IDX_W'(1);
							state_q <= ST_EMIT;
						end
					end else begin
						rem_q  <= div_rem;
						quot_q <= div_quot;
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_EMIT: begin
					if (load) begin
						ovalid_q <= 1'b1;
						if (ptr_q) begin
							olast_q <= (idx_q == IDX_W'(PTR_CHARS - 1));
							if (idx_q == IDX_W'(0))
								ochar_q <= CH_ZERO;
							else if (idx_q == IDX_W'(1))
								ochar_q <= CH_X;
							else begin
								ochar_q <= digit_char(quot_q[VALUE_W-1 -: NIB_W]);
								quot_q  <= {quot_q[VALUE_W-NIB_W-1:0], NIB_W'(0)};
							end
							idx_q <= idx_q + IDX_W'(1);
							if (idx_q == IDX_W'(PTR_CHARS - 1))
								state_q <= ST_IDLE;
						end else if (sign_q) begin
							ochar_q <= CH_MINUS;
							olast_q <= 1'b0;
							sign_q  <= 1'b0;
						end else begin
							ochar_q <= buf_q[rd_idx];
							olast_q <= (idx_q == IDX_W'(1));
							idx_q   <= rd_idx;
							if (idx_q == IDX_W'(1))
								state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: sv/integer_to_ascii_digits.sv
// Top level of the integer to ASCII formatter.
// Depends on itad_pkg, itad_if, itad_front, itad_queue, itad_back.
//
// Usage:
//   num  : number items (cmd, value, signed_mode, base), valid/ready.
//   text : character items (character, last), valid/ready; last marks the
//          final character of each number's run.
//   Integer items print in base 10..16 (out-of-range bases clamp), with a
//   leading minus for negative values in signed mode. Pointer items print
//   "0x" and 16 hex digits.
// Operation:
//   Each integer digit comes from a long division of the whole value (4
//   quotient bits per cycle through one shared divide step); pointer items
//   need no division. The front end takes items into a QDEPTH-entry queue
//   while the back end is busy.
// Reset clears the queue and the back end; nothing is emitted until an item
// arrives. When the text receiver stalls, the output register holds its
// character and the back end waits; num ready drops once the queue is full.
module integer_to_ascii_digits #(
	parameter int QDEPTH = itad_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	itad_num_if.sink    num,
	itad_text_if.source text
);
	import itad_pkg::*;

	q_stat_t                     q_stat;
	desc_t                       push_desc;
	desc_t                       pop_desc;
	logic                        push;
	logic                        pop;
	logic [$clog2(QDEPTH+1)-1:0] q_level;

	itad_front u_front (
		.num       (num),
		.q_stat    (q_stat),
		.push      (push),
		.push_desc (push_desc)
	);

	itad_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.pop_desc  (pop_desc),
		.stat      (q_stat),
		.level     (q_level)
	);

	itad_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop_desc (pop_desc),
		.pop      (pop),
		.text     (text)
	);

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= ($clog2(QDEPTH+1))'(QDEPTH))
		else $error("queue level beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	a_full_level: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop && q_level == ($clog2(QDEPTH+1))'(QDEPTH - 1)) |=> q_stat.full)
		else $error("queue did not fill");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid |-> (text.character >= CH_MINUS && text.character <= CH_X))
		else $error("character outside printed set");
endmodule
